/* hw/rtl/ckl_pkg.sv */
// types and constants shared by the compacting key list cells and top level
`default_nettype none

package ckl_pkg;

  localparam int unsigned MAX_RESULTS = 16;

  // item modes
  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_QUERY  = 3'd1,
    MODE_ALTER  = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_LIST   = 3'd4
  } mode_e;

  // result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_ALTERED = 3'd4;
  localparam logic [2:0] ST_DELETED = 3'd5;
  localparam logic [2:0] ST_ENTRY   = 3'd6;
  localparam logic [2:0] ST_EMPTY   = 3'd7;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         position;
    logic signed [31:0] value;
    logic [4:0]         count;
    logic               last;
  } out_t;

  // commands broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_MARK_MATCH,
    CMD_MARK_ALL,
    CMD_ALTER,
    CMD_ROTATE,
    CMD_CLOSE
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
  } cell_ctl_t;

  // per-cell position qualifiers
  typedef struct packed {
    logic in_range;
    logic at_fill;
    logic shift_here;
  } cell_sel_t;

endpackage

`default_nettype wire

/* hw/rtl/ckl_cell.sv */
// one list cell: a key register and a mark flag, linked to its upper neighbor
`default_nettype none

module ckl_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ckl_pkg::cell_ctl_t ctl_i,
  input  wire ckl_pkg::cell_sel_t sel_i,
  input  wire logic signed [31:0] nb_entry_i,
  input  wire logic               nb_flag_i,
  output logic signed [31:0]      entry_o,
  output logic                    flag_o
);

  logic signed [31:0] entry_q, entry_d;
  logic               flag_q, flag_d;
  logic               match;

  assign match = sel_i.in_range && (entry_q == ctl_i.key);

  always_comb begin
    entry_d = entry_q;
    flag_d  = flag_q;
    case (ctl_i.cmd)
      ckl_pkg::CMD_HOLD: begin
      end
      ckl_pkg::CMD_WRITE: begin
        if (sel_i.at_fill) begin
          entry_d = ctl_i.key;
        end
      end
      ckl_pkg::CMD_MARK_MATCH: begin
        flag_d = match;
      end
      ckl_pkg::CMD_MARK_ALL: begin
        flag_d = sel_i.in_range;
      end
      ckl_pkg::CMD_ALTER: begin
        flag_d = match;
        if (match) begin
          entry_d = ctl_i.new_key;
        end
      end
      ckl_pkg::CMD_ROTATE: begin
        entry_d = nb_entry_i;
        flag_d  = nb_flag_i;
      end
      ckl_pkg::CMD_CLOSE: begin
        if (sel_i.shift_here) begin
          entry_d = nb_entry_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign entry_o = entry_q;
  assign flag_o  = flag_q;

endmodule

`default_nettype wire

/* hw/rtl/compacting_key_list.sv */
// compacting key list: top level with the cell chain and its sequencer
// sequence: insert stores its key at the fill position unless full, then reports in S_FINAL;
//   query, alter, delete and list mark the cells, then rotate the chain CAPACITY steps
//   (one step a cycle while the output is not stalled, at most one result a step); delete
//   then closes its gap, and alter, delete and a query or list with no hit end in S_FINAL
// throughput: one item at a time, set by the CAPACITY-step rotation of the cell chain
// reset: fill count cleared and all marks cleared at once; no clearing pass, keys
//   beyond the fill count are never reported
`default_nettype none

module compacting_key_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ckl_pkg::in_t in_data_i,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output ckl_pkg::out_t     out_data_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i
);

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned FillW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE,
    S_FINAL
  } state_e;

  state_e             state_q;
  logic [FillW-1:0]   fill_q;
  logic [IdxW-1:0]    step_q;
  logic [IdxW-1:0]    del_pos_q;
  logic               found_q;
  logic [FillW-1:0]   cnt_q;
  logic [4:0]         res_q;
  logic [2:0]         op_q;
  ckl_pkg::out_t      fin_q;
  ckl_pkg::out_t      out_q;
  logic               out_valid_q;

  // cell chain wiring
  ckl_pkg::cell_ctl_t       ctl;
  ckl_pkg::cell_sel_t       sel   [CAPACITY];
  logic signed [31:0]       entry [CAPACITY];
  logic [CAPACITY-1:0]      flags;

  // control
  logic out_free;
  logic out_load;
  logic is_report;
  logic emit_now;
  logic advance;
  logic others;
  logic scan_end;

  // width adapters onto the 4-bit position and 5-bit count fields
  logic [IdxW+3:0]  step_ext, del_ext;
  logic [FillW+4:0] fill_ext, fill_inc_ext, fill_dec_ext, alt_ext;
  logic [FillW-1:0] alt_cnt;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_report = (op_q == ckl_pkg::MODE_QUERY) || (op_q == ckl_pkg::MODE_LIST);
  assign emit_now  = (state_q == S_SCAN) && is_report && flags[0] &&
                     (res_q < 5'(ckl_pkg::MAX_RESULTS));
  assign advance   = !emit_now || out_free;
  assign others    = |flags[CAPACITY-1:1];
  assign scan_end  = (step_q == IdxW'(CAPACITY - 1));
  // a new result enters the output slot this cycle
  assign out_load  = (emit_now && out_free) || ((state_q == S_FINAL) && out_free);

  assign alt_cnt      = cnt_q + FillW'(flags[0]);
  assign step_ext     = {4'b0, step_q};
  assign del_ext      = {4'b0, del_pos_q};
  assign fill_ext     = {5'b0, fill_q};
  assign fill_inc_ext = {5'b0, fill_q + FillW'(1)};
  assign fill_dec_ext = {5'b0, fill_q - FillW'(1)};
  assign alt_ext      = {5'b0, alt_cnt};

  // command broadcast to the chain
  always_comb begin
    ctl.cmd     = ckl_pkg::CMD_HOLD;
    ctl.key     = in_data_i.key;
    ctl.new_key = in_data_i.new_key;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.mode)
            ckl_pkg::MODE_INSERT: begin
              if (fill_q < FillW'(CAPACITY)) begin
                ctl.cmd = ckl_pkg::CMD_WRITE;
              end
            end
            ckl_pkg::MODE_QUERY:  ctl.cmd = ckl_pkg::CMD_MARK_MATCH;
            ckl_pkg::MODE_DELETE: ctl.cmd = ckl_pkg::CMD_MARK_MATCH;
            ckl_pkg::MODE_ALTER:  ctl.cmd = ckl_pkg::CMD_ALTER;
            ckl_pkg::MODE_LIST:   ctl.cmd = ckl_pkg::CMD_MARK_ALL;
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // one rotation step: cell 0 shows the entry at list position step_q
        if (advance) begin
          ctl.cmd = ckl_pkg::CMD_ROTATE;
        end
      end
      S_CLOSE: begin
        // list is back in order, close the gap above the deleted position
        if (found_q) begin
          ctl.cmd = ckl_pkg::CMD_CLOSE;
        end
      end
      default: begin
      end
    endcase
  end

  // the chain: each cell takes its upper neighbor, the top cell wraps to cell 0
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int unsigned Nb = (k + 1) % CAPACITY;

    assign sel[k].in_range   = FillW'(k) < fill_q;
    assign sel[k].at_fill    = FillW'(k) == fill_q;
    assign sel[k].shift_here = IdxW'(k) >= del_pos_q;

    ckl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sel_i      (sel[k]),
      .nb_entry_i (entry[Nb]),
      .nb_flag_i  ((k == CAPACITY - 1) ? 1'b0 : flags[Nb]),
      .entry_o    (entry[k]),
      .flag_o     (flags[k])
    );
  end

  // sequencer, fill count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      step_q      <= '0;
      del_pos_q   <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      res_q       <= '0;
      op_q        <= '0;
      fin_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output slot fills on a new result and drains on a transfer
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= in_data_i.mode;
            step_q    <= '0;
            res_q     <= '0;
            cnt_q     <= '0;
            found_q   <= 1'b0;
            del_pos_q <= '0;
            case (in_data_i.mode)
              ckl_pkg::MODE_INSERT: begin
                fin_q.position <= '0;
                fin_q.value    <= '0;
                fin_q.last     <= 1'b1;
                if (fill_q < FillW'(CAPACITY)) begin
                  fill_q       <= fill_q + FillW'(1);
                  fin_q.status <= ckl_pkg::ST_STORED;
                  fin_q.count  <= fill_inc_ext[4:0];
                end else begin
                  fin_q.status <= ckl_pkg::ST_FULL;
                  fin_q.count  <= fill_ext[4:0];
                end
                state_q <= S_FINAL;
              end
              ckl_pkg::MODE_QUERY,
              ckl_pkg::MODE_ALTER,
              ckl_pkg::MODE_DELETE,
              ckl_pkg::MODE_LIST: begin
                state_q <= S_SCAN;
              end
              default: begin
                // unused modes are dropped
              end
            endcase
          end
        end

        S_SCAN: begin
          if (advance) begin
            step_q <= step_q + IdxW'(1);
            if (flags[0]) begin
              cnt_q <= alt_cnt;
              if (!found_q) begin
                found_q   <= 1'b1;
                del_pos_q <= step_q;
              end
            end
            if (emit_now) begin
              // found or entry result, last when no marks remain or at the result cap
              out_q.status   <= (op_q == ckl_pkg::MODE_LIST) ? ckl_pkg::ST_ENTRY
                                                             : ckl_pkg::ST_FOUND;
              out_q.position <= step_ext[3:0];
              out_q.value    <= entry[0];
              out_q.count    <= '0;
              out_q.last     <= !others || (res_q == 5'(ckl_pkg::MAX_RESULTS - 1));
              res_q          <= res_q + 5'd1;
            end
            if (scan_end) begin
              fin_q.position <= '0;
              fin_q.value    <= '0;
              fin_q.last     <= 1'b1;
              case (op_q)
                ckl_pkg::MODE_ALTER: begin
                  fin_q.status <= ckl_pkg::ST_ALTERED;
                  fin_q.count  <= alt_ext[4:0];
                  state_q      <= S_FINAL;
                end
                ckl_pkg::MODE_DELETE: begin
                  state_q <= S_CLOSE;
                end
                default: begin
                  // query or list: nothing reported means one closing result
                  fin_q.count <= '0;
                  if (res_q == 5'd0 && !emit_now) begin
                    fin_q.status <= (op_q == ckl_pkg::MODE_LIST) ? ckl_pkg::ST_EMPTY
                                                                 : ckl_pkg::ST_NONE;
                    state_q      <= S_FINAL;
                  end else begin
                    state_q <= S_IDLE;
                  end
                end
              endcase
            end
          end
        end

        S_CLOSE: begin
          if (found_q) begin
            fill_q         <= fill_q - FillW'(1);
            fin_q.status   <= ckl_pkg::ST_DELETED;
            fin_q.position <= del_ext[3:0];
            fin_q.count    <= fill_dec_ext[4:0];
          end else begin
            fin_q.status <= ckl_pkg::ST_NONE;
            fin_q.count  <= fill_ext[4:0];
          end
          state_q <= S_FINAL;
        end

        S_FINAL: begin
          if (out_free) begin
            out_q   <= fin_q;
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
